// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Implication checked in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/ubr_pkg.sv
package ubr_pkg;

  localparam int unsigned WordW = 64;
  localparam logic [63:0] Uint32Max = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] Uint64Max = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [64:0] Two32 = 65'h0_0000_0001_0000_0000;

  typedef struct packed {
    logic [63:0]        random_word;
    logic [63:0]        span;
    logic signed [63:0] offset;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic signed [63:0] value;
    logic               bad_span;
  } out_word_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic logic [63:0] div_step(input logic [63:0] r, input logic b,
                                           input logic [63:0] d);
    logic [64:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[63:0];
  endfunction

endpackage

// File: hw/rtl/unbiased_bounded_random_unit.sv
// Unbiased bounded random value by rejection sampling. Each input word gives
// one result word: accepted with offset + (word mod span), a rejection (supply
// a fresh random word), or bad_span; in 32-bit mode word is its low half and
// offset is zero. Two 64-step restoring dividers run side by side, one bit per
// pipeline stage, for word mod span and the threshold (2^W - span) mod span.
// One word is taken per cycle unless the output stalls; a stalled output
// freezes the whole pipeline: entry stage, 64 divide stages, output register.
`include "assert_macros.svh"

module unbiased_bounded_random_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ubr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ubr_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_data
);
  import ubr_pkg::*;

  localparam int Depth = WordW;

  logic              word_mode;
  logic              adv;
  logic [Depth:0]    v;
  logic [63:0]       wrd  [Depth+1];
  logic [63:0]       tdv  [Depth+1];
  logic [63:0]       spn  [Depth+1];
  logic [63:0]       off  [Depth+1];
  logic [63:0]       arem [Depth+1];
  logic [63:0]       brem [Depth+1];
  logic [Depth:0]    bad;
  logic [64:0]       thr65;
  logic [63:0]       word_in;
  logic              bad_in;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      word_mode <= cfg_data[0];
    end
  end

  always_comb begin
    if (word_mode) begin
      word_in = in_data.random_word;
      thr65   = {1'b0, Uint64Max - in_data.span} + 65'd1;
      bad_in  = (in_data.span == '0);
    end else begin
      word_in = in_data.random_word & Uint32Max;
      thr65   = Two32 - {1'b0, in_data.span};
      bad_in  = (in_data.span == '0) || (in_data.span > Uint32Max);
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wrd[0]  <= word_in;
      tdv[0]  <= thr65[63:0];
      spn[0]  <= in_data.span;
      off[0]  <= word_mode ? in_data.offset : '0;
      arem[0] <= '0;
      brem[0] <= '0;
      bad[0]  <= bad_in;
    end
  end

  // divide stages, MSB first
  for (genvar k = 1; k <= Depth; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        wrd[k]  <= wrd[k-1];
        tdv[k]  <= tdv[k-1];
        spn[k]  <= spn[k-1];
        off[k]  <= off[k-1];
        bad[k]  <= bad[k-1];
        arem[k] <= div_step(arem[k-1], wrd[k-1][Depth-k], spn[k-1]);
        brem[k] <= div_step(brem[k-1], tdv[k-1][Depth-k], spn[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[Depth];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.bad_span <= bad[Depth];
      // reject words below the threshold
      if (!bad[Depth] && (wrd[Depth] >= brem[Depth])) begin
        out_data.accepted <= 1'b1;
        out_data.value    <= off[Depth] + arem[Depth];
      end else begin
        out_data.accepted <= 1'b0;
        out_data.value    <= '0;
      end
    end
  end

  `ASSERT_IMPLIES(a_bad_no_value, clk, rst, out_valid && out_data.bad_span,
                  !out_data.accepted && out_data.value == '0)
  `ASSERT_IMPLIES(a_reject_zero, clk, rst, out_valid && !out_data.accepted,
                  out_data.value == '0)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall,
               out_valid && $stable(out_data))

endmodule

// File: verif/unbiased_bounded_random_unit_test.sv
`timescale 1ns / 1ps

module unbiased_bounded_random_unit_test;
  import ubr_pkg::*;

  localparam int LatencyCycles = 66;
  localparam int IdleLimit = 20000;
  localparam int NumRandom = 2000;

  typedef enum logic [0:0] {MODE_LOW32 = 1'b0, MODE_FULL64 = 1'b1} word_mode_e;

  class range_scoreboard;
    out_word_t pending_q[$];
    word_mode_e mode;
    int errors;

    function new();
      mode = MODE_LOW32;
      errors = 0;
    endfunction

    // Reduce one word to the bounded value under the current mode.
    function out_word_t reduce(in_word_t w);
      out_word_t r;
      logic [31:0] s32, w32, thr32;
      logic [63:0] thr64;
      r = '0;
      if (mode == MODE_LOW32) begin
        if (w.span == 64'd0 || w.span > Uint32Max) begin
          r.bad_span = 1'b1;
        end else begin
          s32 = w.span[31:0];
          w32 = w.random_word[31:0];
          thr32 = (32'd0 - s32) % s32;
          if (w32 >= thr32) begin
            r.accepted = 1'b1;
            r.value = {32'd0, w32 % s32};
          end
        end
      end else begin
        if (w.span == 64'd0) begin
          r.bad_span = 1'b1;
        end else begin
          thr64 = (64'd0 - w.span) % w.span;
          if (w.random_word >= thr64) begin
            r.accepted = 1'b1;
            r.value = w.offset + (w.random_word % w.span);
          end
        end
      end
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_q.push_back(reduce(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.accepted !== exp_w.accepted) begin
        $error("accepted: expected %0d actual %0d", exp_w.accepted, got.accepted);
        errors++;
      end
      if (got.value !== exp_w.value) begin
        $error("value: expected %h actual %h", exp_w.value, got.value);
        errors++;
      end
      if (got.bad_span !== exp_w.bad_span) begin
        $error("bad_span: expected %0d actual %0d", exp_w.bad_span, got.bad_span);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_data;

  range_scoreboard sb;
  int idle_cycles;
  bit stall_enable;

  unbiased_bounded_random_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check results and count cycles with no word moving.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)
          || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver stall pattern: each cycle picks heavy, light or no stalling.
  always @(posedge clk) begin
    if (rst || !stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      case ((idle_cycles + $urandom) % 4)
        0: out_stall <= ($urandom_range(0, 1) == 1);
        1: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_span(word_mode_e m);
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'd1;
      2: return Uint32Max;
      3: return Uint32Max + 64'd1;
      4: return Uint64Max;
      5: return {32'd0, $urandom} | 64'h8000_0000;
      6: return 64'd1 << $urandom_range(0, 63);
      7: return (m == MODE_LOW32) ? 64'(3 * (64'd1 << 30)) : 64'hC000_0000_0000_0000;
      8: return rand64();
      default: return 64'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  task automatic write_mode(word_mode_e m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.mode = m;
  endtask

  task automatic run_directed(word_mode_e m);
    in_word_t w;
    logic [63:0] spans [8];
    spans = '{64'd0, 64'd1, 64'd3, Uint32Max, Uint32Max + 64'd1, Uint64Max,
              64'h8000_0000_0000_0001, 64'h0000_0000_8000_0001};
    for (int i = 0; i < 8; i++) begin
      w.span = spans[i];
      w.random_word = (i % 2) ? 64'd0 : Uint64Max;
      w.offset = (i % 3 == 0) ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      send_word(w);
    end
    // Word just below and at the threshold of a span that rejects.
    w.span = 64'h8000_0000_0000_0001;
    w.offset = -64'sd1;
    w.random_word = 64'h7FFF_FFFF_FFFF_FFFE;
    send_word(w);
    w.random_word = 64'h7FFF_FFFF_FFFF_FFFF;
    send_word(w);
    w.span = 64'h0000_0000_8000_0001;
    w.random_word = 64'hFFFF_FFFF_7FFF_FFFE;
    send_word(w);
    w.random_word = 64'h0000_0000_7FFF_FFFF;
    send_word(w);
  endtask

  task automatic run_random(word_mode_e m, int count);
    in_word_t w;
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < count; i++) begin
        w.random_word = rand64();
        w.span = pick_span(m);
        w.offset = rand64();
        send_word(w);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    stall_enable = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = MODE_LOW32;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed(MODE_LOW32);
    drain();
    stall_enable = 1'b1;
    write_mode(MODE_FULL64);
    run_directed(MODE_FULL64);
    run_random(MODE_FULL64, NumRandom / 2);
    drain();
    write_mode(MODE_LOW32);
    run_random(MODE_LOW32, NumRandom / 4);
    drain();
    write_mode(MODE_FULL64);
    run_random(MODE_FULL64, NumRandom / 4);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: unbiased_bounded_random_unit.f
+incdir+hw/rtl
hw/rtl/ubr_pkg.sv
hw/rtl/unbiased_bounded_random_unit.sv
verif/unbiased_bounded_random_unit_test.sv
